// ===== hw/rtl/rwa_pkg.sv =====
// ----------------------------------------------------------------------------
// rwa_pkg
// Shared widths, codes and record types of the ring walker automaton step.
// ----------------------------------------------------------------------------
package rwa_pkg;

  // Lattice and field sizes
  localparam int MAX_SITES   = 1024;
  localparam int LABEL_BITS  = 16;
  localparam int CNT_BITS    = $clog2(MAX_SITES);
  localparam int INDEX_BITS  = 10;
  localparam int CFG_BITS    = 11;
  localparam int TALLY_BITS  = 11;
  localparam int TALLY_MAX   = (1 << TALLY_BITS) - 1;

  // One step record carries up to five site results
  localparam int SLOTS       = 5;
  localparam int SLOT_BITS   = $clog2(SLOTS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef logic [1:0]            occ_t;
  typedef logic [LABEL_BITS-1:0] label_t;

  // Occupancy codes
  localparam occ_t OCC_EMPTY = 2'd0;
  localparam occ_t OCC_RIGHT = 2'd1;
  localparam occ_t OCC_LEFT  = 2'd2;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CELL_COUNT   = 2'd0,
    REG_TRACK_LABELS = 2'd1,
    REG_COUNT_MOVES  = 2'd2
  } reg_index_t;

  typedef struct packed {
    occ_t   value;
    label_t label;
  } site_res_t;

  // Front-to-back record: one ordinary site, or the five closing sites
  typedef struct packed {
    logic                  is_last;
    logic [INDEX_BITS-1:0] base_index;
    logic [TALLY_BITS-1:0] moved;
    site_res_t [SLOTS-1:0] slot;
  } step_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== hw/rtl/rwa_front.sv =====
// ----------------------------------------------------------------------------
// rwa_front
// Takes in sites, keeps the neighbour window and the wrap-around head,
// applies the neighbour rules and hands step records to the queue.
// ----------------------------------------------------------------------------
module rwa_front import rwa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                accept,
  input  occ_t                site_value,
  input  label_t              site_label,
  input  logic                random_heading,
  output logic                rec_push,
  output step_rec_t           rec
);

  typedef struct packed {
    occ_t   value;
    label_t label;
    logic   moved;
  } rule_res_t;

  // Neighbour rules, in order of priority
  function automatic rule_res_t apply_rule(input occ_t x, input occ_t e, input occ_t w,
                                           input occ_t ee, input occ_t ww, input label_t lx,
                                           input label_t le, input label_t lw,
                                           input logic rnd_bit);
    rule_res_t r;
    occ_t      rnd;
    rnd = rnd_bit ? OCC_LEFT : OCC_RIGHT;
    r.value = OCC_EMPTY;
    r.label = lx;
    r.moved = 1'b0;
    if (x == OCC_RIGHT && e == OCC_EMPTY) begin
      if (ee == OCC_LEFT) begin
        r.value = rnd;
      end else begin
        r.moved = 1'b1;
        r.label = '0;
      end
    end else if (x == OCC_LEFT && w == OCC_EMPTY) begin
      if (ww == OCC_RIGHT) begin
        r.value = rnd;
      end else begin
        r.moved = 1'b1;
        r.label = '0;
      end
    end else if (x == OCC_RIGHT || x == OCC_LEFT) begin
      r.value = rnd;
    end else if (e == OCC_LEFT && w == OCC_RIGHT) begin
      r.value = OCC_EMPTY;
    end else if (e == OCC_LEFT) begin
      r.value = rnd;
      r.label = le;
    end else if (w == OCC_RIGHT) begin
      r.value = rnd;
      r.label = lw;
    end
    return r;
  endfunction

  // Configuration registers
  logic [CFG_BITS-1:0] cell_count;
  logic                track_labels;
  logic                count_moves;

  // Window and head of the step
  occ_t                win_val [4];
  label_t              win_lab [3];
  logic                win_hd  [2];
  occ_t                head_val [4];
  label_t              head_lab [3];
  logic                head_hd  [2];
  logic [CNT_BITS-1:0] site_counter;
  logic [TALLY_BITS-1:0] move_tally;

  occ_t                cv;
  occ_t                ev [9];
  label_t              el [7];
  logic                eh [5];
  rule_res_t           res [SLOTS];
  logic [CFG_BITS-1:0] n;
  logic                is_last;
  logic                emits;
  logic [2:0]          move_sum;
  logic [TALLY_BITS:0] tally_sum;
  logic [TALLY_BITS-1:0] move_tally_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count   <= CFG_BITS'(MAX_SITES);
      track_labels <= 1'b0;
      count_moves  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CELL_COUNT:   cell_count   <= cfg_data;
        REG_TRACK_LABELS: track_labels <= cfg_data[0];
        REG_COUNT_MOVES:  count_moves  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Occupancy three reads as empty
  assign cv = (site_value == 2'd3) ? OCC_EMPTY : site_value;

  // Ring size clamped to its legal range
  always_comb begin
    n = cell_count;
    if (cell_count < CFG_BITS'(5)) n = CFG_BITS'(5);
    else if (32'(cell_count) > MAX_SITES) n = CFG_BITS'(MAX_SITES);
  end

  assign is_last = (32'(site_counter) + 1) >= 32'(n);
  assign emits   = is_last || (32'(site_counter) >= 4);

  // Extended neighbourhood: window, arriving site, head
  always_comb begin
    for (int i = 0; i < 4; i++) ev[i] = win_val[i];
    ev[4] = cv;
    for (int i = 0; i < 4; i++) ev[5 + i] = head_val[i];
    for (int i = 0; i < 3; i++) el[i] = win_lab[i];
    el[3] = site_label;
    for (int i = 0; i < 3; i++) el[4 + i] = head_lab[i];
    eh[0] = win_hd[0];
    eh[1] = win_hd[1];
    eh[2] = random_heading;
    eh[3] = head_hd[0];
    eh[4] = head_hd[1];
  end

  // Rules for the five candidate sites, independent of each other
  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      res[j] = apply_rule(ev[j + 2], ev[j + 3], ev[j + 1], ev[j + 4], ev[j],
                          el[j + 1], el[j + 2], el[j], eh[j]);
    end
  end

  // Move tally, saturating
  always_comb begin
    move_sum = {2'b00, res[0].moved};
    if (is_last) begin
      move_sum = 3'(res[0].moved) + 3'(res[1].moved) + 3'(res[2].moved)
               + 3'(res[3].moved) + 3'(res[4].moved);
    end
    if (!count_moves) move_sum = '0;
    tally_sum = {1'b0, move_tally} + (TALLY_BITS + 1)'(move_sum);
    move_tally_next = (tally_sum > (TALLY_BITS + 1)'(TALLY_MAX)) ? TALLY_BITS'(TALLY_MAX)
                                                               : tally_sum[TALLY_BITS-1:0];
  end

  // Record to the back end
  always_comb begin
    rec.is_last    = is_last;
    rec.base_index = INDEX_BITS'(site_counter) - INDEX_BITS'(2);
    rec.moved      = move_tally_next;
    for (int j = 0; j < SLOTS; j++) begin
      rec.slot[j].value = res[j].value;
      rec.slot[j].label = track_labels ? res[j].label : '0;
    end
  end

  assign rec_push = accept && emits;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      site_counter <= '0;
      move_tally   <= '0;
      for (int i = 0; i < 4; i++) win_val[i] <= OCC_EMPTY;
      for (int i = 0; i < 3; i++) win_lab[i] <= '0;
      win_hd[0] <= 1'b0;
      win_hd[1] <= 1'b0;
    end else if (accept) begin
      site_counter <= is_last ? '0 : site_counter + CNT_BITS'(1);
      if (is_last)    move_tally <= '0;
      else if (emits) move_tally <= move_tally_next;
      win_val[0] <= win_val[1];
      win_val[1] <= win_val[2];
      win_val[2] <= win_val[3];
      win_val[3] <= cv;
      win_lab[0] <= win_lab[1];
      win_lab[1] <= win_lab[2];
      win_lab[2] <= site_label;
      win_hd[0]  <= win_hd[1];
      win_hd[1]  <= random_heading;
    end
  end

  // Head of the step, kept for wrap-around
  always_ff @(posedge clk) begin
    if (accept) begin
      if (32'(site_counter) < 4) head_val[site_counter[1:0]] <= cv;
      if (32'(site_counter) < 3) head_lab[site_counter[1:0]] <= site_label;
      if (32'(site_counter) < 2) head_hd[site_counter[0]]    <= random_heading;
    end
  end

endmodule

// ===== hw/rtl/rwa_queue.sv =====
// ----------------------------------------------------------------------------
// rwa_queue
// Short first-in first-out queue of step records between front and back.
// ----------------------------------------------------------------------------
module rwa_queue import rwa_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  step_rec_t     wr_rec,
  input  logic          pop,
  output step_rec_t     rd_rec,
  output queue_status_t status
);

  step_rec_t            entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   fill;
  logic                 do_push;
  logic                 do_pop;

  assign status.full  = (fill == (QPTR_BITS + 1)'(QUEUE_DEPTH));
  assign status.empty = (fill == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rd_rec       = entries[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_BITS'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_BITS'(1);
      case ({do_push, do_pop})
        2'b10:   fill <= fill + (QPTR_BITS + 1)'(1);
        2'b01:   fill <= fill - (QPTR_BITS + 1)'(1);
        default: ;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= wr_rec;
  end

endmodule

// ===== hw/rtl/rwa_back.sv =====
// ----------------------------------------------------------------------------
// rwa_back
// Unpacks step records into site results into the output register, one per
// cycle while a record waits and the output is free or being popped.
// ----------------------------------------------------------------------------
module rwa_back import rwa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  step_rec_t             rec,
  input  logic                  rec_empty,
  output logic                  rec_pop,
  input  logic                  pop,
  output logic                  empty,
  output logic [INDEX_BITS-1:0] site_index,
  output occ_t                  new_value,
  output label_t                new_label,
  output logic [TALLY_BITS-1:0] moved_count,
  output logic                  last_of_step
);

  logic [SLOT_BITS-1:0] slot;
  logic                 out_valid;
  logic                 load;
  logic                 slot_done;

  assign empty     = !out_valid;
  assign load      = !rec_empty && (!out_valid || pop);
  assign slot_done = !rec.is_last || (32'(slot) == SLOTS - 1);
  assign rec_pop   = load && slot_done;

  // Slot walk and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) slot <= slot_done ? '0 : slot + SLOT_BITS'(1);
      if (load)     out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      new_value    <= rec.slot[slot].value;
      new_label    <= rec.slot[slot].label;
      last_of_step <= rec.is_last && slot_done;
      moved_count  <= (rec.is_last && slot_done) ? rec.moved : '0;
      if (32'(slot) < 3) site_index <= rec.base_index + INDEX_BITS'(slot);
      else               site_index <= INDEX_BITS'(slot) - INDEX_BITS'(3);
    end
  end

endmodule

// ===== hw/rtl/ring_walker_automaton_step.sv =====
// ----------------------------------------------------------------------------
// ring_walker_automaton_step
// One time step of a periodic random-walker lattice over a stream of sites.
// Flow: a site's result is formed when the site two places further on is
//   taken, goes through the record queue into the output register; the
//   closing sites follow the last site, one per cycle while popped.
// Throughput: one site per cycle in while the queue is not full; one result
//   per cycle out while the output register is popped, so the last site of
//   a step yields five results, absorbed by a four-record queue.
// Reset: synchronous rst clears window, counters and queue, resets config.
// ----------------------------------------------------------------------------
module ring_walker_automaton_step import rwa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            site_value,
  input  logic [LABEL_BITS-1:0] site_label,
  input  logic                  random_heading,
  output logic                  empty,
  input  logic                  pop,
  output logic [INDEX_BITS-1:0] site_index,
  output logic [1:0]            new_value,
  output logic [LABEL_BITS-1:0] new_label,
  output logic [TALLY_BITS-1:0] moved_count,
  output logic                  last_of_step
);

  logic          accept;
  logic          rec_push;
  logic          rec_pop;
  step_rec_t     front_rec;
  step_rec_t     back_rec;
  queue_status_t q_status;

  assign full   = q_status.full;
  assign accept = push && !q_status.full;

  // Front: window, rules, records
  rwa_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .accept         (accept),
    .site_value     (site_value),
    .site_label     (site_label),
    .random_heading (random_heading),
    .rec_push       (rec_push),
    .rec            (front_rec)
  );

  // Record queue
  rwa_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (rec_push),
    .wr_rec (front_rec),
    .pop    (rec_pop),
    .rd_rec (back_rec),
    .status (q_status)
  );

  // Back: result issue
  rwa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .rec          (back_rec),
    .rec_empty    (q_status.empty),
    .rec_pop      (rec_pop),
    .pop          (pop),
    .empty        (empty),
    .site_index   (site_index),
    .new_value    (new_value),
    .new_label    (new_label),
    .moved_count  (moved_count),
    .last_of_step (last_of_step)
  );

endmodule

// ===== test/ring_walker_automaton_step_test.sv =====
// ----------------------------------------------------------------------------
// ring_walker_automaton_step_test
// Streams lattice steps of random walkers through the block and checks every
// site result against a cycle-free predictor of the neighbour rules. Ring
// size, label tracking and move counting are changed between steps, ring
// size also in the middle of a step. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module ring_walker_automaton_step_test import rwa_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   RANDOM_SITES  = 130;
  localparam int   MIN_SITES     = 5;
  localparam int   SETTLE_CYCLES = 12;
  localparam int   CYCLE_LIMIT   = 400000;
  localparam occ_t OCC_INVALID   = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    bit [INDEX_BITS-1:0] index;
    bit [1:0]            value;
    bit [LABEL_BITS-1:0] label;
    bit [TALLY_BITS-1:0] moved;
    bit                  last;
  } site_result_t;

  // Predicts the next state of every site and holds the results still owed
  class lattice_step_board;
    site_result_t        next_sites_q[$];
    bit [CFG_BITS-1:0]   ring_size;
    bit                  track_on;
    bit                  tally_on;
    bit [1:0]            win_val[5];
    bit [LABEL_BITS-1:0] win_lab[3];
    bit                  win_hd[3];
    bit [1:0]            head_val[4];
    bit [LABEL_BITS-1:0] head_lab[3];
    bit                  head_hd[2];
    bit [CFG_BITS-1:0]   counter;
    bit [TALLY_BITS-1:0] tally;
    // neighbourhood around the arriving site: values 0..8, labels 1..7,
    // headings 2..6 (offset by one and two)
    bit [1:0]            nb_val[9];
    bit [LABEL_BITS-1:0] nb_lab[7];
    bit                  nb_hd[5];
    int                  errors;
    int                  compared;
    int                  steps;

    function new();
      ring_size = CFG_BITS'(MAX_SITES);
    endfunction

    function void note_config(logic [1:0] idx, logic [CFG_BITS-1:0] data);
      case (idx)
        REG_CELL_COUNT:   ring_size = data;
        REG_TRACK_LABELS: track_on  = data[0];
        REG_COUNT_MOVES:  tally_on  = data[0];
        default: ;
      endcase
    endfunction

    // Seven neighbour rules for the site at neighbourhood position p
    function site_result_t settle_site(int p, bit [CFG_BITS-1:0] idx);
      bit [1:0]            x, e, w, ee, ww, rnd, y;
      bit [LABEL_BITS-1:0] lab;
      bit                  moved;
      site_result_t        r;
      x     = nb_val[p];
      e     = nb_val[p+1];
      w     = nb_val[p-1];
      ee    = nb_val[p+2];
      ww    = nb_val[p-2];
      rnd   = nb_hd[p-2] ? OCC_LEFT : OCC_RIGHT;
      lab   = nb_lab[p-1];
      y     = OCC_EMPTY;
      moved = 1'b0;
      if (x == OCC_RIGHT && e == OCC_EMPTY) begin
        if (ee == OCC_LEFT) y = rnd;
        else begin
          moved = 1'b1;
          lab   = '0;
        end
      end else if (x == OCC_LEFT && w == OCC_EMPTY) begin
        if (ww == OCC_RIGHT) y = rnd;
        else begin
          moved = 1'b1;
          lab   = '0;
        end
      end else if (x == OCC_RIGHT || x == OCC_LEFT) begin
        y = rnd;
      end else if (e == OCC_LEFT && w == OCC_RIGHT) begin
        y = OCC_EMPTY;
      end else if (e == OCC_LEFT) begin
        y   = rnd;
        lab = nb_lab[p];
      end else if (w == OCC_RIGHT) begin
        y   = rnd;
        lab = nb_lab[p-2];
      end
      if (moved && tally_on && tally < TALLY_MAX) tally++;
      r.index = idx[INDEX_BITS-1:0];
      r.value = y;
      r.label = track_on ? lab : '0;
      r.moved = '0;
      r.last  = 1'b0;
      return r;
    endfunction

    // Accepted site transaction; returns 1 when it closed the step
    function bit note_site(bit [1:0] v, bit [LABEL_BITS-1:0] l, bit h);
      bit [CFG_BITS-1:0] n;
      bit [1:0]          cv;
      site_result_t      closing[5];
      bit                closed;
      cv = (v == OCC_INVALID) ? OCC_EMPTY : v;
      n  = ring_size;
      if (n < MIN_SITES) n = CFG_BITS'(MIN_SITES);
      if (n > MAX_SITES) n = CFG_BITS'(MAX_SITES);
      closed = 1'b0;

      for (int i = 0; i < 4; i++) nb_val[i] = win_val[i+1];
      nb_val[4] = cv;
      for (int i = 0; i < 4; i++) nb_val[5+i] = head_val[i];
      for (int i = 0; i < 3; i++) nb_lab[i] = win_lab[i];
      nb_lab[3] = l;
      for (int i = 0; i < 3; i++) nb_lab[4+i] = head_lab[i];
      nb_hd[0] = win_hd[1];
      nb_hd[1] = win_hd[2];
      nb_hd[2] = h;
      nb_hd[3] = head_hd[0];
      nb_hd[4] = head_hd[1];

      // first sites of the step are kept for the wrap-around
      if (counter < 4) head_val[counter[1:0]] = cv;
      if (counter < 3) head_lab[counter[1:0]] = l;
      if (counter < 2) head_hd[counter[0]]    = h;

      if (counter >= n - 1) begin
        closing[0] = settle_site(2, CFG_BITS'(counter - 2));
        closing[1] = settle_site(3, CFG_BITS'(counter - 1));
        closing[2] = settle_site(4, counter);
        closing[3] = settle_site(5, '0);
        closing[4] = settle_site(6, CFG_BITS'(1));
        closing[4].moved = tally;
        closing[4].last  = 1'b1;
        foreach (closing[i]) next_sites_q.push_back(closing[i]);
        counter = '0;
        tally   = '0;
        closed  = 1'b1;
        steps++;
      end else begin
        if (counter >= 4) next_sites_q.push_back(settle_site(2, CFG_BITS'(counter - 2)));
        counter++;
      end

      for (int i = 0; i < 4; i++) win_val[i] = win_val[i+1];
      win_val[4] = cv;
      win_lab[0] = win_lab[1];
      win_lab[1] = win_lab[2];
      win_lab[2] = l;
      win_hd[0]  = win_hd[1];
      win_hd[1]  = win_hd[2];
      win_hd[2]  = h;
      return closed;
    endfunction

    // Accepted result transaction against the oldest prediction
    function void check_result(bit [INDEX_BITS-1:0] idx, bit [1:0] v,
                               bit [LABEL_BITS-1:0] l, bit [TALLY_BITS-1:0] m,
                               bit last);
      site_result_t want;
      if (next_sites_q.size() == 0) begin
        $error("result for site %0d with nothing predicted", idx);
        errors++;
        return;
      end
      want = next_sites_q.pop_front();
      compared++;
      if (idx != want.index) begin
        $error("site_index: expected %0d, got %0d", want.index, idx);
        errors++;
      end
      if (v != want.value) begin
        $error("new_value: expected %0d, got %0d", want.value, v);
        errors++;
      end
      if (l != want.label) begin
        $error("new_label: expected %0h, got %0h", want.label, l);
        errors++;
      end
      if (m != want.moved) begin
        $error("moved_count: expected %0d, got %0d", want.moved, m);
        errors++;
      end
      if (last != want.last) begin
        $error("last_of_step: expected %0d, got %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [1:0]            cfg_index = '0;
  logic [CFG_BITS-1:0]   cfg_data = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic [1:0]            site_value = '0;
  logic [LABEL_BITS-1:0] site_label = '0;
  logic                  random_heading = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [INDEX_BITS-1:0] site_index;
  logic [1:0]            new_value;
  logic [LABEL_BITS-1:0] new_label;
  logic [TALLY_BITS-1:0] moved_count;
  logic                  last_of_step;

  lattice_step_board board;
  bit                calm;
  bit                step_closed;
  int                stall_left;
  int                rand_sites;
  int                sites_sent;
  int                cycles;
  bit [1:0]          pattern_q[$];
  bit [CFG_BITS-1:0] size;
  int                eff;
  int                cut_at;

  ring_walker_automaton_step i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .full           (full),
    .site_value     (site_value),
    .site_label     (site_label),
    .random_heading (random_heading),
    .empty          (empty),
    .pop            (pop),
    .site_index     (site_index),
    .new_value      (new_value),
    .new_label      (new_label),
    .moved_count    (moved_count),
    .last_of_step   (last_of_step)
  );

  always #10 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic bit [LABEL_BITS-1:0] pick_label();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return LABEL_BITS'($urandom_range(0, 65535));
  endfunction

  function automatic bit [1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return OCC_EMPTY;
    if (r < 65) return OCC_RIGHT;
    if (r < 90) return OCC_LEFT;
    return OCC_INVALID;
  endfunction

  function automatic int clamp_size(bit [CFG_BITS-1:0] s);
    if (s < MIN_SITES) return MIN_SITES;
    if (s > MAX_SITES) return MAX_SITES;
    return s;
  endfunction

  // Result side: check each accepted transaction, stall at random
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (pop && !empty)
        board.check_result(site_index, new_value, new_label, moved_count,
                           last_of_step);
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.note_config(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Holds push high until the site transaction is taken
  task automatic push_site(input bit [1:0] v, input bit [LABEL_BITS-1:0] l,
                           input bit h);
    push           <= 1'b1;
    site_value     <= v;
    site_label     <= l;
    random_heading <= h;
    do @(posedge clk); while (full);
    step_closed = board.note_site(v, l, h);
    sites_sent++;
  endtask

  task automatic idle_gap();
    int g;
    g = calm ? 0 : pick_gap();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic push_rand();
    push_site(pick_value(), pick_label(), 1'($urandom_range(0, 1)));
    rand_sites++;
    idle_gap();
  endtask

  task automatic push_step();
    do push_rand(); while (!step_closed);
  endtask

  task automatic push_values(input bit [1:0] vals[$]);
    foreach (vals[i]) begin
      push_site(vals[i], (i % 2) ? '1 : pick_label(), 1'(i % 2));
      idle_gap();
    end
  endtask

  // Sender waits for every predicted result, then for the pipe to settle
  task automatic drain();
    push <= 1'b0;
    while (board.next_sites_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Ring size zero clamps to five; several rules on a five-site ring
    write_reg(REG_CELL_COUNT, '0);
    write_reg(REG_TRACK_LABELS, CFG_BITS'(1));
    write_reg(REG_COUNT_MOVES, CFG_BITS'(1));
    write_reg(REG_UNUSED, '1);
    pattern_q = '{OCC_RIGHT, OCC_EMPTY, OCC_LEFT, OCC_RIGHT, OCC_EMPTY};
    push_values(pattern_q);
    drain();

    // Seven sites: blocked and unblocked walkers, occupancy three as empty
    write_reg(REG_CELL_COUNT, CFG_BITS'(7));
    pattern_q = '{OCC_LEFT, OCC_EMPTY, OCC_EMPTY, OCC_LEFT, OCC_LEFT, OCC_RIGHT,
                  OCC_INVALID};
    push_values(pattern_q);
    drain();

    // Size just under the minimum, labels and tally off
    write_reg(REG_CELL_COUNT, CFG_BITS'(4));
    write_reg(REG_TRACK_LABELS, '0);
    write_reg(REG_COUNT_MOVES, '0);
    push_step();
    drain();

    // Ring shrunk mid-step below the current position
    write_reg(REG_CELL_COUNT, CFG_BITS'(8));
    write_reg(REG_TRACK_LABELS, CFG_BITS'(1));
    write_reg(REG_COUNT_MOVES, CFG_BITS'(1));
    repeat (6) push_rand();
    drain();
    write_reg(REG_CELL_COUNT, CFG_BITS'(5));
    push_step();

    // Random steps with random settings
    rand_sites = 0;
    while (rand_sites < RANDOM_SITES) begin
      drain();
      case ($urandom_range(0, 9))
        0:       size = CFG_BITS'($urandom_range(0, 4));
        1:       size = $urandom_range(0, 1) ? CFG_BITS'(MAX_SITES) : '1;
        2, 3:    size = CFG_BITS'($urandom_range(11, 32));
        default: size = CFG_BITS'($urandom_range(5, 10));
      endcase
      eff = clamp_size(size);
      write_reg(REG_CELL_COUNT, size);
      write_reg(REG_TRACK_LABELS, CFG_BITS'($urandom_range(0, 1)));
      write_reg(REG_COUNT_MOVES, CFG_BITS'($urandom_range(0, 1)));
      calm = ($urandom_range(0, 4) == 0);
      if (eff > 64 || (eff >= 6 && $urandom_range(0, 3) == 0)) begin
        // new size mid-step: closes at once or lets the step run on
        cut_at = $urandom_range(4, (eff - 2 < 30) ? eff - 2 : 30);
        repeat (cut_at) push_rand();
        drain();
        write_reg(REG_CELL_COUNT, CFG_BITS'($urandom_range(0, 40)));
        push_step();
      end else begin
        repeat ($urandom_range(1, 3)) push_step();
      end
    end
    calm = 1'b0;
    drain();

    $display("tb: %0d sites over %0d ring steps, %0d results compared",
             sites_sent, board.steps, board.compared);
    $display("tb: ring settings from zero to oversized, mid-step resizing, %s",
             "labels and tally on/off");
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== ring_walker_automaton_step.f =====
hw/rtl/rwa_pkg.sv
hw/rtl/rwa_front.sv
hw/rtl/rwa_queue.sv
hw/rtl/rwa_back.sv
hw/rtl/ring_walker_automaton_step.sv
test/ring_walker_automaton_step_test.sv
